[rtl/fat_chain_allocator_assert.svh]
// ----------------------------------------------------------------------------
// fat_chain_allocator_assert.svh
// Assertion macros used by the fca_ctrl sequencer. Each macro expects
// clk and rst_n in scope and checks only while out of reset.
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define FCA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FCA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fca_pkg.sv]
// ----------------------------------------------------------------------------
// fca_pkg
// Types and constants of the allocation table chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int CFG_W       = 11;   // width of block counts and scan pointer
    localparam int IDX_W       = 10;   // width of a block index
    localparam int INDEX_SPACE = 1024; // blocks reachable by a 10-bit index

    localparam logic [CFG_W-1:0] BLOCK_TOTAL_RST = 11'd1024;
    localparam logic [CFG_W-1:0] DATA_FIRST_RST  = 11'd65;

    // Configuration register indexes
    localparam logic CFG_BLOCK_TOTAL = 1'b0;
    localparam logic CFG_DATA_FIRST  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FREE     = 2'd0,
        KIND_LINK     = 2'd1,
        KIND_END      = 2'd2,
        KIND_RESERVED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] next;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FORMAT,
        ST_COUNT,
        ST_ALLOC,
        ST_ALLOC_END,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_LOAD,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        TALLY_HOLD,
        TALLY_CLEAR,
        TALLY_INC
    } tally_op_t;

    typedef enum logic {
        BOUND_LIMIT,
        BOUND_DEPTH
    } bound_t;

    // Sequencer to scan unit
    typedef struct packed {
        ptr_op_t          ptr_op;
        tally_op_t        tally_op;
        bound_t           bound;
        logic [CFG_W-1:0] ptr_val;
    } scan_ctl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic [CFG_W-1:0] ptr;
        logic             in_range;
        logic             tally_ge;
        logic             tally_last;
        logic             tally_zero;
    } scan_sts_t;

    // Table port requests
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

endpackage

[rtl/fat_chain_allocator.sv]
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Allocation table chain allocator: format, allocate, free and look up
// chains in a table of one entry per disk block.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream, one transfer per command; each gives
//   exactly one result transfer on the m_ stream. Registers block_total and
//   data_first_block are written through the cfg_ channel; the user must write
//   them only while idle, and the block itself does not enforce it.
//   Commands share one scan pointer and one table read port:
//     format   : a sweep over every table entry, one table write per cycle
//     allocate : a counting pass and a linking pass from the data start,
//                one entry per cycle each
//     free     : a read and then a check for each chain block
//     lookup   : one table read, then a check of the entry
//   s_tready is high only while no command is in progress.
//   After reset the table's min(TABLE_DEPTH, 1024) entries are cleared to free,
//   one entry per cycle; s_tready stays low meanwhile.
//   A result sits in the output register until m_tready takes it; the next
//   command is accepted meanwhile, and its own result waits for room.
// ----------------------------------------------------------------------------
module fat_chain_allocator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] block_index, [20:10] block_count, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] result_index, rest zero
    output logic [3:0]  m_tuser,   // [0] status, [2:1] entry_kind, [3] chain_empty
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    import fca_pkg::*;

    // Entries past the 10-bit index space are never reachable
    localparam int MEM_DEPTH = (TABLE_DEPTH < INDEX_SPACE) ? TABLE_DEPTH : INDEX_SPACE;
    localparam logic [CFG_W-1:0] MEM_DEPTH_W = CFG_W'(MEM_DEPTH);

    logic [CFG_W-1:0] block_total_reg;
    logic [CFG_W-1:0] data_first_reg;
    logic [CFG_W-1:0] limit;
    logic [CFG_W-1:0] count;
    logic             out_valid_reg;
    logic             out_free;
    logic             res_load;
    logic             res_status;
    logic [IDX_W-1:0] res_index;
    kind_t            res_kind;
    logic             res_empty;
    logic             status_reg;
    logic [IDX_W-1:0] index_reg;
    kind_t            kind_reg;
    logic             empty_reg;
    scan_ctl_t        scan_ctl;
    scan_sts_t        scan_sts;
    mem_req_t         mem_req;
    entry_t           rd_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_total_reg <= BLOCK_TOTAL_RST;
            data_first_reg  <= DATA_FIRST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLOCK_TOTAL: block_total_reg <= cfg_data;
                CFG_DATA_FIRST:  data_first_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Usable range bound for scans and walks
    assign limit = (block_total_reg < MEM_DEPTH_W) ? block_total_reg : MEM_DEPTH_W;

    fca_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_take      (s_tvalid),
        .s_ready     (s_tready),
        .cmd         (cmd_t'(s_tuser)),
        .block_index (s_tdata[9:0]),
        .block_count (s_tdata[20:10]),
        .block_total (block_total_reg),
        .data_first  (data_first_reg),
        .out_free    (out_free),
        .res_load    (res_load),
        .res_status  (res_status),
        .res_index   (res_index),
        .res_kind    (res_kind),
        .res_empty   (res_empty),
        .count       (count),
        .scan_ctl    (scan_ctl),
        .scan_sts    (scan_sts),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    fca_scan #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_ctl (scan_ctl),
        .limit    (limit),
        .count    (count),
        .scan_sts (scan_sts)
    );

    fca_table #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Output register: hold the result until the receiver takes it
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg <= res_status;
            index_reg  <= res_index;
            kind_reg   <= res_kind;
            empty_reg  <= res_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, index_reg};
    assign m_tuser  = {empty_reg, kind_reg, status_reg};

endmodule

[rtl/fca_table.sv]
// ----------------------------------------------------------------------------
// fca_table
// Allocation table storage: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fca_table #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic              clk,
    input  fca_pkg::mem_req_t mem_req,
    output fca_pkg::entry_t   rd_data
);
    import fca_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    entry_t mem [MEM_DEPTH];
    entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
    end

    // Read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fca_scan.sv]
// ----------------------------------------------------------------------------
// fca_scan
// Shared scan unit: block pointer with range compare, and a tally counter
// compared against the requested block count.
// ----------------------------------------------------------------------------
module fca_scan #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fca_pkg::scan_ctl_t            scan_ctl,
    input  logic [fca_pkg::CFG_W-1:0]     limit,
    input  logic [fca_pkg::CFG_W-1:0]     count,
    output fca_pkg::scan_sts_t            scan_sts
);
    import fca_pkg::*;

    localparam logic [CFG_W-1:0] DEPTH_W = CFG_W'(MEM_DEPTH);

    logic [CFG_W-1:0] ptr_reg;
    logic [CFG_W-1:0] ptr_next;
    logic [CFG_W-1:0] tally_reg;
    logic [CFG_W-1:0] tally_next;
    logic [CFG_W-1:0] bound;
    logic [CFG_W:0]   tally_plus;

    // Pick the pointer's next value
    always_comb
    begin
        unique case (scan_ctl.ptr_op)
            PTR_LOAD: ptr_next = scan_ctl.ptr_val;
            PTR_INC:  ptr_next = ptr_reg + 1'b1;
            default:  ptr_next = ptr_reg;
        endcase
    end

    // Pick the tally's next value
    always_comb
    begin
        unique case (scan_ctl.tally_op)
            TALLY_CLEAR: tally_next = '0;
            TALLY_INC:   tally_next = tally_reg + 1'b1;
            default:     tally_next = tally_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            tally_reg <= tally_next;
        end
    end

    // Compare pointer against the selected bound, tally against the count
    assign bound      = (scan_ctl.bound == BOUND_DEPTH) ? DEPTH_W : limit;
    assign tally_plus = {1'b0, tally_reg} + 1'b1;

    assign scan_sts.ptr        = ptr_reg;
    assign scan_sts.in_range   = ptr_reg < bound;
    assign scan_sts.tally_ge   = tally_reg >= count;
    assign scan_sts.tally_last = tally_plus == {1'b0, count};
    assign scan_sts.tally_zero = tally_reg == '0;

endmodule

[rtl/fca_ctrl.sv]
// ----------------------------------------------------------------------------
// fca_ctrl
// Command sequencer: clearing pass, format sweep, two-pass allocation,
// chain walk for free, and lookup; drives the table and the scan unit.
// ----------------------------------------------------------------------------
`include "fat_chain_allocator_assert.svh"

module fca_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_take,
    output logic                          s_ready,
    input  fca_pkg::cmd_t                 cmd,
    input  logic [fca_pkg::IDX_W-1:0]     block_index,
    input  logic [fca_pkg::CFG_W-1:0]     block_count,
    input  logic [fca_pkg::CFG_W-1:0]     block_total,
    input  logic [fca_pkg::CFG_W-1:0]     data_first,
    input  logic                          out_free,
    output logic                          res_load,
    output logic                          res_status,
    output logic [fca_pkg::IDX_W-1:0]     res_index,
    output fca_pkg::kind_t                res_kind,
    output logic                          res_empty,
    output logic [fca_pkg::CFG_W-1:0]     count,
    output fca_pkg::scan_ctl_t            scan_ctl,
    input  fca_pkg::scan_sts_t            scan_sts,
    output fca_pkg::mem_req_t             mem_req,
    input  fca_pkg::entry_t               rd_data
);
    import fca_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic             pend_reg;
    logic             issue;
    logic [IDX_W-1:0] paddr_reg;
    logic [IDX_W-1:0] prev_reg;
    logic [CFG_W-1:0] count_reg;
    logic             status_reg;
    logic [IDX_W-1:0] index_reg;
    kind_t            kind_reg;
    logic             empty_reg;
    logic             accept;
    logic             hit;
    logic             cnt_stop;
    logic             fmt_reserved;

    assign accept       = s_take && s_ready;
    assign hit          = pend_reg && (rd_data.kind == KIND_FREE);
    assign cnt_stop     = scan_sts.tally_ge || (!scan_sts.in_range && !pend_reg);
    assign fmt_reserved = (scan_sts.ptr < data_first) && (scan_sts.ptr < block_total);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!scan_sts.in_range) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_INIT:   state_next = ST_FORMAT;
                        CMD_ALLOC:  state_next = (block_count == '0) ? ST_RESULT : ST_COUNT;
                        CMD_FREE:   state_next = ST_WALK_RD;
                        default:    state_next = ST_LOOK_RD;
                    endcase
                end
            end
            ST_FORMAT:
            begin
                if (!scan_sts.in_range) state_next = ST_RESULT;
            end
            ST_COUNT:
            begin
                if (cnt_stop) state_next = scan_sts.tally_ge ? ST_ALLOC : ST_RESULT;
            end
            ST_ALLOC:
            begin
                if (hit && scan_sts.tally_last) state_next = ST_ALLOC_END;
            end
            ST_ALLOC_END: state_next = ST_RESULT;
            ST_WALK_RD:   state_next = scan_sts.in_range ? ST_WALK_CHK : ST_RESULT;
            ST_WALK_CHK:  state_next = (rd_data.kind == KIND_LINK) ? ST_WALK_RD : ST_RESULT;
            ST_LOOK_RD:   state_next = scan_sts.in_range ? ST_LOOK_CHK : ST_RESULT;
            ST_LOOK_CHK:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs: table requests, scan unit control, result strobe
    always_comb
    begin
        mem_req           = '0;
        scan_ctl.ptr_op   = PTR_HOLD;
        scan_ctl.tally_op = TALLY_HOLD;
        scan_ctl.bound    = BOUND_LIMIT;
        scan_ctl.ptr_val  = '0;
        issue             = 1'b0;
        res_load          = 1'b0;
        s_ready           = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                scan_ctl.bound = BOUND_DEPTH;
                if (scan_sts.in_range)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = scan_sts.ptr[IDX_W-1:0];
                    mem_req.wr_data = '{kind: KIND_FREE, next: '0};
                    scan_ctl.ptr_op = PTR_INC;
                end
            end
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (accept)
                begin
                    scan_ctl.ptr_op   = PTR_LOAD;
                    scan_ctl.tally_op = TALLY_CLEAR;
                    unique case (cmd)
                        CMD_INIT:   scan_ctl.ptr_val = '0;
                        CMD_ALLOC:  scan_ctl.ptr_val = data_first;
                        default:    scan_ctl.ptr_val = {1'b0, block_index};
                    endcase
                end
            end
            ST_FORMAT:
            begin
                scan_ctl.bound = BOUND_DEPTH;
                if (scan_sts.in_range)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = scan_sts.ptr[IDX_W-1:0];
                    mem_req.wr_data = '{kind: (fmt_reserved ? KIND_RESERVED : KIND_FREE),
                                        next: '0};
                    scan_ctl.ptr_op = PTR_INC;
                end
            end
            ST_COUNT:
            begin
                if (cnt_stop)
                begin
                    // Enough space: rewind for the chain-building pass
                    if (scan_sts.tally_ge)
                    begin
                        scan_ctl.ptr_op   = PTR_LOAD;
                        scan_ctl.ptr_val  = data_first;
                        scan_ctl.tally_op = TALLY_CLEAR;
                    end
                end
                else
                begin
                    if (hit) scan_ctl.tally_op = TALLY_INC;
                    if (scan_sts.in_range)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = scan_sts.ptr[IDX_W-1:0];
                        scan_ctl.ptr_op = PTR_INC;
                        issue           = 1'b1;
                    end
                end
            end
            ST_ALLOC:
            begin
                // Link the previous block to this free one
                if (hit)
                begin
                    scan_ctl.tally_op = TALLY_INC;
                    if (!scan_sts.tally_zero)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = prev_reg;
                        mem_req.wr_data = '{kind: KIND_LINK, next: paddr_reg};
                    end
                end
                if (!(hit && scan_sts.tally_last) && scan_sts.in_range)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_sts.ptr[IDX_W-1:0];
                    scan_ctl.ptr_op = PTR_INC;
                    issue           = 1'b1;
                end
            end
            ST_ALLOC_END:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = prev_reg;
                mem_req.wr_data = '{kind: KIND_END, next: '0};
            end
            ST_WALK_RD:
            begin
                if (scan_sts.in_range)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_sts.ptr[IDX_W-1:0];
                end
            end
            ST_WALK_CHK:
            begin
                if (rd_data.kind == KIND_LINK || rd_data.kind == KIND_END)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = scan_sts.ptr[IDX_W-1:0];
                    mem_req.wr_data = '{kind: KIND_FREE, next: '0};
                end
                if (rd_data.kind == KIND_LINK)
                begin
                    scan_ctl.ptr_op  = PTR_LOAD;
                    scan_ctl.ptr_val = {1'b0, rd_data.next};
                end
            end
            ST_LOOK_RD:
            begin
                scan_ctl.bound = BOUND_DEPTH;
                if (scan_sts.in_range)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_sts.ptr[IDX_W-1:0];
                end
            end
            ST_LOOK_CHK:
            begin
            end
            ST_RESULT:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
        end
    end

    // Scan bookkeeping and result fields
    always_ff @(posedge clk)
    begin
        paddr_reg <= scan_sts.ptr[IDX_W-1:0];
        if (accept)
        begin
            count_reg  <= block_count;
            status_reg <= 1'b0;
            index_reg  <= '0;
            kind_reg   <= KIND_FREE;
            empty_reg  <= (cmd == CMD_ALLOC) && (block_count == '0);
        end
        case (state_reg)
            ST_COUNT:
            begin
                if (cnt_stop && !scan_sts.tally_ge) status_reg <= 1'b1;
            end
            ST_ALLOC:
            begin
                if (hit)
                begin
                    prev_reg <= paddr_reg;
                    if (scan_sts.tally_zero) index_reg <= paddr_reg;
                end
            end
            ST_LOOK_RD:
            begin
                if (!scan_sts.in_range) kind_reg <= KIND_RESERVED;
            end
            ST_LOOK_CHK:
            begin
                kind_reg  <= rd_data.kind;
                index_reg <= (rd_data.kind == KIND_LINK) ? rd_data.next : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign count      = count_reg;
    assign res_status = status_reg;
    assign res_index  = index_reg;
    assign res_kind   = kind_reg;
    assign res_empty  = empty_reg;

    // Writes only touch entries already passed by the read side
    `FCA_ASSERT_IMP(a_no_rw_clash, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr, "table read and write hit the same entry")
    // The counting pass guarantees the chain completes inside the limit
    `FCA_ASSERT_IMP(a_alloc_in_bounds, state_reg == ST_ALLOC, scan_sts.in_range || pend_reg, "allocation scan ran past the limit")
    // A finished result waits until the output register has room
    `FCA_ASSERT_NXT(a_result_holds, state_reg == ST_RESULT && !out_free, state_reg == ST_RESULT, "result left while output register full")

endmodule
